@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the scope trace block.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ast_pkg.sv @@
// Package of the autoscaling scope trace: field widths, level limits, FSM states.
// No dependencies; used by the pixel interface, the top level and the testbench.
`default_nettype none

package ast_pkg;

    localparam int COL_W   = 7;
    localparam int LVL_W   = 6;
    localparam int SCALE_W = 7;
    localparam int CNT_W   = 7;

    localparam int MID_LEVEL     = 25;
    localparam int LARGE_LIMIT   = 12;
    localparam int TOP_LEVEL     = 50;
    localparam int SCALE_MAX     = 64;
    localparam int LARGE_FEW     = 4;
    localparam int OVERFLOW_MANY = 8;
    localparam int COUNT_MAX     = 127;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QDIV,
        S_EVAL,
        S_ERASE,
        S_DRAW,
        S_STEP,
        S_MDIV,
        S_MFIN
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/ast_smp_if.sv @@
// Sample channel: valid/ready handshake carrying one ADC conversion result.
// Standalone interface; width set by parameter W.
`default_nettype none

interface ast_smp_if #(
    parameter int W = 10
);
    logic         valid;
    logic         ready;
    logic [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ast_pix_if.sv @@
// Pixel update channel: valid/ready handshake carrying one trace pixel update.
// Depends on ast_pkg for the field widths.
`default_nettype none

interface ast_pix_if;
    import ast_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [LVL_W-1:0] level;
    logic             pixel_on;
    logic             final_update;

    modport source (output valid, output column, output level, output pixel_on,
                    output final_update, input ready);
    modport sink   (input valid, input column, input level, input pixel_on,
                    input final_update, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/autoscale_scope_trace.sv @@
// Autoscaling scope trace: bias removal, serial scaling divide, trace update.
// Depends on ast_pkg, ast_smp_if, ast_pix_if and assert_macros.svh.
//
// Usage:
//   i_smp takes one ADC sample per transaction; each sample fills the next
//   column of a sweep of SWEEP_LEN columns. o_pix returns either nothing (the
//   column level did not change) or two transactions: an erase at the old
//   level, then a draw at the new level with final_update set.
//   A sample is divided by the scale in the bit-serial divider, which yields
//   one quotient bit per cycle; no new sample is taken until the updates for
//   the last one are loaded into the output register or found unneeded.
//   The last column of a sweep then also waits while the same divider forms
//   the sweep mean for the new bias, one bit a cycle.
//   The draw sits in the output register, so the next sample is taken while it
//   waits. If the receiver stalls, the block waits in erase or draw until the
//   output register frees up; no pixel update is dropped.
//   Reset clears the column, the sum, the bias, both counters, the trace store
//   (per-column valid bits, cleared at once) and sets the scale to 1.
`default_nettype none
`include "assert_macros.svh"

module autoscale_scope_trace #(
    parameter int SWEEP_LEN   = 88,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ast_smp_if.sink    i_smp,
    ast_pix_if.source  o_pix
);
    import ast_pkg::*;

    localparam int IDX_W  = $clog2(SWEEP_LEN);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int ITER_W = $clog2(SUM_W + 1);
    localparam int DIV_W  = ($clog2(SWEEP_LEN + 1) > SCALE_W) ?
                            $clog2(SWEEP_LEN + 1) : SCALE_W;
    localparam int PAD_W  = SUM_W - SAMPLE_BITS;

    t_state r_state, n_state;

    logic [COL_W-1:0]       r_col;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_bias;
    logic [SCALE_W-1:0]     r_scale;
    logic [CNT_W-1:0]       r_ovf;
    logic [CNT_W-1:0]       r_lrg;

    // shared serial divider
    logic [SUM_W-1:0]  r_dq;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_divisor;
    logic [ITER_W-1:0] r_iter;
    logic              r_neg;

    // trace store
    logic [LVL_W-1:0] mem_trace [SWEEP_LEN];
    logic             r_vld [SWEEP_LEN];
    logic [LVL_W-1:0] r_rd;
    logic             r_rd_vld;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] r_old;

    // output register
    logic             r_o_valid;
    logic [COL_W-1:0] r_o_column;
    logic [LVL_W-1:0] r_o_level;
    logic             r_o_on;
    logic             r_o_final;

    logic                   in_ready, in_acc, out_free, ld_erase, ld_draw;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   smp_neg;
    logic [SAMPLE_BITS-1:0] smp_mag;
    logic [DIV_W:0]         div_shift;
    logic                   div_ge;
    logic [DIV_W-1:0]       div_rem;
    logic [SAMPLE_BITS-1:0] quo;
    logic [LVL_W-1:0]       quo_clip;
    logic [LVL_W:0]         up_sum;
    logic [LVL_W-1:0]       new_lvl;
    logic [LVL_W-1:0]       old_lvl;
    logic                   last_col;

    assign smp     = i_smp.sample;
    assign in_acc  = i_smp.valid && in_ready;
    assign smp_neg = smp < r_bias;
    assign smp_mag = smp_neg ? (r_bias - smp) : (smp - r_bias);

    assign out_free = !r_o_valid || o_pix.ready;
    assign last_col = r_col == COL_W'(SWEEP_LEN - 1);

    // one restoring step per cycle
    assign div_shift = {r_rem, r_dq[SUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_divisor};
    assign div_rem   = div_ge ? DIV_W'(div_shift - {1'b0, r_divisor}) : div_shift[DIV_W-1:0];

    // level from the finished quotient
    assign quo      = r_dq[SAMPLE_BITS-1:0];
    assign quo_clip = (quo > SAMPLE_BITS'(TOP_LEVEL)) ? LVL_W'(TOP_LEVEL) : quo[LVL_W-1:0];
    assign up_sum   = (LVL_W + 1)'(MID_LEVEL) + {1'b0, quo_clip};
    assign old_lvl  = r_rd_vld ? r_rd : '0;

    always_comb begin
        if (r_neg) begin
            new_lvl = (quo_clip > LVL_W'(MID_LEVEL)) ? '0 : LVL_W'(MID_LEVEL) - quo_clip;
        end else begin
            new_lvl = (up_sum > (LVL_W + 1)'(TOP_LEVEL)) ? LVL_W'(TOP_LEVEL)
                                                       : up_sum[LVL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        ld_erase = 1'b0;
        ld_draw  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_smp.valid) begin
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                if (r_iter == ITER_W'(1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = (new_lvl != old_lvl) ? S_ERASE : S_STEP;
            end
            S_ERASE: begin
                if (out_free) begin
                    ld_erase = 1'b1;
                    n_state  = S_DRAW;
                end
            end
            S_DRAW: begin
                if (out_free) begin
                    ld_draw = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = last_col ? S_MDIV : S_IDLE;
            end
            S_MDIV: begin
                if (r_iter == ITER_W'(1)) begin
                    n_state = S_MFIN;
                end
            end
            S_MFIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sweep state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_sum   <= '0;
            r_bias  <= '0;
            r_scale <= SCALE_W'(1);
            r_ovf   <= '0;
            r_lrg   <= '0;
        end else begin
            if (in_acc) begin
                r_sum <= r_sum + SUM_W'(smp);
            end
            if (r_state == S_EVAL) begin
                if (quo > SAMPLE_BITS'(MID_LEVEL)) begin
                    if (r_ovf != CNT_W'(COUNT_MAX)) begin
                        r_ovf <= r_ovf + CNT_W'(1);
                    end
                end else if (quo > SAMPLE_BITS'(LARGE_LIMIT)) begin
                    if (r_lrg != CNT_W'(COUNT_MAX)) begin
                        r_lrg <= r_lrg + CNT_W'(1);
                    end
                end
            end
            if (r_state == S_STEP) begin
                r_col <= last_col ? '0 : r_col + COL_W'(1);
                if (last_col) begin
                    r_sum <= '0;
                end
            end
            if (r_state == S_MFIN) begin
                r_bias <= r_dq[SAMPLE_BITS-1:0];
                priority if (r_lrg < CNT_W'(LARGE_FEW) && r_scale > SCALE_W'(1)) begin
                    r_scale <= r_scale - SCALE_W'(1);
                end else if (r_ovf > CNT_W'(OVERFLOW_MANY)
                             && r_scale < SCALE_W'(SCALE_MAX)) begin
                    r_scale <= r_scale + SCALE_W'(1);
                end
                r_ovf <= '0;
                r_lrg <= '0;
            end
        end
    end

    // divider: sample magnitude over scale, or sweep sum over sweep length
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg     <= smp_neg;
            r_dq      <= {smp_mag, {PAD_W{1'b0}}};
            r_rem     <= '0;
            r_divisor <= DIV_W'(r_scale);
            r_iter    <= ITER_W'(SAMPLE_BITS);
        end else if (r_state == S_STEP && last_col) begin
            r_dq      <= r_sum;
            r_rem     <= '0;
            r_divisor <= DIV_W'(SWEEP_LEN);
            r_iter    <= ITER_W'(SUM_W);
        end else if (r_state == S_QDIV || r_state == S_MDIV) begin
            r_dq   <= {r_dq[SUM_W-2:0], div_ge};
            r_rem  <= div_rem;
            r_iter <= r_iter - ITER_W'(1);
        end
        if (r_state == S_EVAL) begin
            r_lvl <= new_lvl;
            r_old <= old_lvl;
        end
    end

    // trace store: read at accept, written with the draw
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= mem_trace[r_col[IDX_W-1:0]];
        end
        if (ld_draw) begin
            mem_trace[r_col[IDX_W-1:0]] <= r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SWEEP_LEN; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rd_vld <= r_vld[r_col[IDX_W-1:0]];
            end
            if (ld_draw) begin
                r_vld[r_col[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ld_erase || ld_draw) begin
            r_o_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_erase) begin
            r_o_column <= r_col;
            r_o_level  <= r_old;
            r_o_on     <= 1'b0;
            r_o_final  <= 1'b0;
        end else if (ld_draw) begin
            r_o_column <= r_col;
            r_o_level  <= r_lvl;
            r_o_on     <= 1'b1;
            r_o_final  <= 1'b1;
        end
    end

    assign i_smp.ready        = in_ready;
    assign o_pix.valid        = r_o_valid;
    assign o_pix.column       = r_o_column;
    assign o_pix.level        = r_o_level;
    assign o_pix.pixel_on     = r_o_on;
    assign o_pix.final_update = r_o_final;

    `AST_ASSERT_NOW(a_scale_range, 1'b1, r_scale >= SCALE_W'(1) && r_scale <= SCALE_W'(SCALE_MAX), "vertical scale out of range")
    `AST_ASSERT_NOW(a_col_range, 1'b1, r_col < COL_W'(SWEEP_LEN), "column beyond sweep")
    `AST_ASSERT_NEXT(a_acc_div, in_acc, r_state == S_QDIV && r_iter == ITER_W'(SAMPLE_BITS), "divider not started on sample")
    `AST_ASSERT_NEXT(a_erase_draw, ld_erase, r_state == S_DRAW && r_o_valid && !r_o_on, "erase not followed by draw")
    `AST_ASSERT_NEXT(a_draw_last, ld_draw, r_o_valid && r_o_on && r_o_final && r_vld[r_o_column[IDX_W-1:0]], "draw not marked final")

endmodule

`default_nettype wire

@@ bench/tb_autoscale_scope_trace.sv @@
// Testbench for autoscale_scope_trace: random and directed ADC samples in, pixel updates out,
// each update checked against a trace predictor kept in step with every sample transaction.
// Depends on ast_pkg, ast_smp_if, ast_pix_if and the autoscale_scope_trace RTL.
`default_nettype none

module tb_autoscale_scope_trace;
    import ast_pkg::*;

    localparam int SWEEP_LEN   = 88;
    localparam int SAMPLE_BITS = 10;
    localparam int N_ITEMS     = 900;
    localparam int CALM_TAIL   = 100;
    localparam int SETTLE      = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   drain;  // hold off until all pixel updates are back
    } t_adc_item;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [LVL_W-1:0] level;
        logic             pixel_on;
        logic             final_update;
    } t_pix_update;

    typedef enum int {
        SWP_QUIET,
        SWP_LOUD,
        SWP_FLAT,
        SWP_WILD
    } t_sweep_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ast_smp_if #(.W(SAMPLE_BITS)) smp_ch ();
    ast_pix_if                    pix_ch ();

    autoscale_scope_trace #(
        .SWEEP_LEN   (SWEEP_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_ch),
        .o_pix   (pix_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Trace predictor state
    logic [COL_W-1:0]       sweep_col;
    logic [16:0]            sweep_sum;
    logic [SAMPLE_BITS-1:0] bias;
    logic [SCALE_W-1:0]     scale;
    logic [CNT_W-1:0]       ovf_cnt;
    logic [CNT_W-1:0]       big_cnt;
    logic [LVL_W-1:0]       trace_lvl [SWEEP_LEN];

    t_adc_item   adc_queue [$];
    t_pix_update pix_expected [$];
    t_adc_item   adc_cur;
    t_pix_update pix_want;

    bit smp_live;
    bit calm;
    int gap_left;
    int stall_left;
    int mismatches;
    int cycle_count;

    function automatic void trace_reset();
        sweep_col = '0;
        sweep_sum = '0;
        bias      = '0;
        scale     = SCALE_W'(1);
        ovf_cnt   = '0;
        big_cnt   = '0;
        foreach (trace_lvl[i])
            trace_lvl[i] = '0;
    endfunction

    // Works out the pixel updates one sample causes and advances the sweep.
    function automatic void trace_update(input logic [SAMPLE_BITS-1:0] smp);
        bit          neg;
        int unsigned mag;
        int unsigned quo;
        int          lvl;
        t_pix_update px;

        sweep_sum = sweep_sum + smp;
        neg = smp < bias;
        mag = neg ? int'(bias) - int'(smp) : int'(smp) - int'(bias);
        quo = mag / int'(scale);

        if (quo > MID_LEVEL) begin
            if (ovf_cnt < COUNT_MAX)
                ovf_cnt++;
        end else if (quo > LARGE_LIMIT) begin
            if (big_cnt < COUNT_MAX)
                big_cnt++;
        end

        if (quo > TOP_LEVEL)
            quo = TOP_LEVEL;
        lvl = neg ? MID_LEVEL - int'(quo) : MID_LEVEL + int'(quo);
        if (lvl < 0)
            lvl = 0;
        if (lvl > TOP_LEVEL)
            lvl = TOP_LEVEL;

        if (lvl[LVL_W-1:0] != trace_lvl[sweep_col]) begin
            px = '{column: sweep_col, level: trace_lvl[sweep_col],
                   pixel_on: 1'b0, final_update: 1'b0};
            pix_expected.push_back(px);
            px = '{column: sweep_col, level: lvl[LVL_W-1:0],
                   pixel_on: 1'b1, final_update: 1'b1};
            pix_expected.push_back(px);
            trace_lvl[sweep_col] = lvl[LVL_W-1:0];
        end

        if (int'(sweep_col) == SWEEP_LEN - 1) begin
            sweep_col = '0;
            bias      = SAMPLE_BITS'(sweep_sum / SWEEP_LEN);
            sweep_sum = '0;
            if (big_cnt < LARGE_FEW && scale > 1)
                scale--;
            else if (ovf_cnt > OVERFLOW_MANY && scale < SCALE_MAX)
                scale++;
            ovf_cnt = '0;
            big_cnt = '0;
        end else begin
            sweep_col++;
        end
    endfunction

    // Sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid  <= 1'b0;
            smp_ch.sample <= '0;
            smp_live = 1'b0;
            gap_left = 0;
            trace_reset();
        end else begin
            if (smp_ch.valid && smp_ch.ready) begin
                trace_update(smp_ch.sample);
                smp_live = 1'b0;
            end
            calm = adc_queue.size() < CALM_TAIL;
            if (!smp_live) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (adc_queue.size() != 0 &&
                             !(adc_queue[0].drain && pix_expected.size() != 0)) begin
                    if (!calm && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(1, 7) - 1;
                    end else begin
                        adc_cur = adc_queue.pop_front();
                        smp_ch.sample <= adc_cur.sample;
                        smp_live = 1'b1;
                    end
                end
            end
            smp_ch.valid <= smp_live;
        end
    end

    // Pixel receiver: stall bursts until the calm tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            pix_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            pix_ch.ready <= 1'b0;
        end else begin
            pix_ch.ready <= 1'b1;
        end
    end

    // Pixel monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            if (pix_expected.size() == 0) begin
                $error("pixel update col %0d lvl %0d with nothing expected",
                       pix_ch.column, pix_ch.level);
                mismatches++;
            end else begin
                pix_want = pix_expected.pop_front();
                if (pix_ch.column !== pix_want.column) begin
                    $error("column: expected %0d, actual %0d", pix_want.column, pix_ch.column);
                    mismatches++;
                end
                if (pix_ch.level !== pix_want.level) begin
                    $error("level: expected %0d, actual %0d", pix_want.level, pix_ch.level);
                    mismatches++;
                end
                if (pix_ch.pixel_on !== pix_want.pixel_on) begin
                    $error("pixel_on: expected %0d, actual %0d",
                           pix_want.pixel_on, pix_ch.pixel_on);
                    mismatches++;
                end
                if (pix_ch.final_update !== pix_want.final_update) begin
                    $error("final_update: expected %0d, actual %0d",
                           pix_want.final_update, pix_ch.final_update);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int          directed [];
        int          k;
        int          centre;
        int          spread;
        int          v;
        t_sweep_kind kind;
        t_adc_item   it;

        directed      = '{0, 0, 1023, 1023, 12, 13, 25, 26, 38, 39, 50, 51,
                          2, 1, 512, 682, 341, 1000, 24, 0};
        i_rst_n       = 1'b0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        pix_ch.ready  = 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        calm          = 1'b0;
        centre        = 512;
        spread        = 0;
        kind          = SWP_WILD;

        foreach (directed[i]) begin
            it.sample = SAMPLE_BITS'(directed[i]);
            it.drain  = 1'b0;
            adc_queue.push_back(it);
        end

        for (k = directed.size(); k < N_ITEMS; k++) begin
            // new signal shape at each sweep boundary and at the first random sample
            if (k % SWEEP_LEN == 0 || k == directed.size()) begin
                kind = t_sweep_kind'($urandom_range(0, 9) < 4 ? SWP_LOUD :
                                     $urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0)
                    centre = $urandom_range(0, 1023);
                case (kind)
                    SWP_QUIET: spread = $urandom_range(0, 3);
                    SWP_LOUD:  spread = $urandom_range(100, 511);
                    SWP_FLAT:  spread = 0;
                    default:   spread = $urandom_range(12, 60);
                endcase
            end
            if (kind == SWP_WILD && $urandom_range(0, 1) == 0)
                v = $urandom_range(0, 1023);
            else
                v = centre + $urandom_range(0, 2 * spread) - spread;
            if (v < 0)
                v = 0;
            if (v > 1023)
                v = 1023;
            it.sample = SAMPLE_BITS'(v);
            it.drain  = (k % 200 == 0);
            adc_queue.push_back(it);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (adc_queue.size() != 0 || smp_live || pix_expected.size() != 0);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0 && pix_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
